@@ rtl/psc_pkg.sv @@
// Shared types, constants and the arctangent table of the pursuit steering controller.
package psc_pkg;

  // Item kinds carried in tuser
  localparam logic [1:0] KIND_TARGET = 2'd0;
  localparam logic [1:0] KIND_OWN    = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;

  // Register indexes
  localparam logic REG_MAX_SPEED = 1'b0;
  localparam logic REG_TURN_GAIN = 1'b1;

  // Field widths
  localparam int POS_W   = 19;
  localparam int HEAD_W  = 15;
  localparam int SPEED_W = 16;
  localparam int GAIN_W  = 12;
  localparam int RATE_W  = 19;
  localparam int CFG_W   = 16;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 40;

  // Defaults
  localparam int FRAC_BITS_DEF   = 12;
  localparam int CORDIC_ITER_DEF = 16;

  localparam logic [SPEED_W-1:0] MAX_SPEED_RST = 16'd8192;
  localparam logic [GAIN_W-1:0]  TURN_GAIN_RST = 12'd1024;

  // Datapath widths
  localparam int DXW        = POS_W + 1;  // position difference
  localparam int GUARD_BITS = 8;
  localparam int XW         = 31;         // CORDIC x and y
  localparam int ZW         = 34;         // CORDIC angle, Q30 radians
  localparam int BW         = 20;         // bearing, up to seventeen fraction bits
  localparam int DW         = 21;         // angle error
  localparam int MW         = 32;         // multiplier operand
  localparam int PW         = 2 * MW;     // multiplier product

  localparam logic signed [ZW-1:0] PI_Q30    = 34'sd3373259426;
  localparam logic signed [MW-1:0] KCOMP_Q30 = 32'sd652032874;

  localparam int RATE_SHIFT = 8;  // turn_gain carries eight fraction bits
  localparam int DIST_SHIFT = 30 + GUARD_BITS;

  typedef struct packed {
    logic                   done;
    logic signed [XW-1:0]   x;
    logic signed [ZW-1:0]   z;
  } cordic_res_t;

  typedef struct packed {
    logic                     done;
    logic [SPEED_W-1:0]       speed;
    logic signed [RATE_W-1:0] rate;
  } post_res_t;

  // atan(2^-i) in Q30 radians
  function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] idx);
    logic signed [ZW-1:0] a;
    case (idx)
      5'd0:  a = 34'sd843314857;
      5'd1:  a = 34'sd497837829;
      5'd2:  a = 34'sd263043837;
      5'd3:  a = 34'sd133525159;
      5'd4:  a = 34'sd67021687;
      5'd5:  a = 34'sd33543516;
      5'd6:  a = 34'sd16775851;
      5'd7:  a = 34'sd8388437;
      5'd8:  a = 34'sd4194283;
      5'd9:  a = 34'sd2097149;
      5'd10: a = 34'sd1048576;
      5'd11: a = 34'sd524288;
      5'd12: a = 34'sd262144;
      5'd13: a = 34'sd131072;
      5'd14: a = 34'sd65536;
      5'd15: a = 34'sd32768;
      5'd16: a = 34'sd16384;
      5'd17: a = 34'sd8192;
      5'd18: a = 34'sd4096;
      5'd19: a = 34'sd2048;
      5'd20: a = 34'sd1024;
      5'd21: a = 34'sd512;
      5'd22: a = 34'sd256;
      5'd23: a = 34'sd128;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

@@ rtl/psc_cordic.sv @@
// Iterative vectoring CORDIC: one shift-add rotation per cycle.
module psc_cordic #(
  parameter int ITERS = psc_pkg::CORDIC_ITER_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [psc_pkg::DXW-1:0]    dx_i,
  input  logic signed [psc_pkg::DXW-1:0]    dy_i,
  output psc_pkg::cordic_res_t              res_o
);
  import psc_pkg::*;

  localparam int IW = $clog2(ITERS);

  logic signed [XW-1:0] x_q, x_d, y_q, y_d, xs, ys, x0, y0;
  logic signed [ZW-1:0] z_q, z_d, ang;
  logic [IW-1:0]        iter_q, iter_d;
  logic                 busy_q, busy_d, done_q, done_d;

  assign xs  = x_q >>> iter_q;
  assign ys  = y_q >>> iter_q;
  assign ang = atan_q30(5'(iter_q));
  assign x0  = {{(XW - DXW - GUARD_BITS){dx_i[DXW-1]}}, dx_i, {GUARD_BITS{1'b0}}};
  assign y0  = {{(XW - DXW - GUARD_BITS){dy_i[DXW-1]}}, dy_i, {GUARD_BITS{1'b0}}};

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    iter_d = iter_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      iter_d = '0;
      if (dx_i == '0 && dy_i == '0) begin
        // zero vector: bearing and distance both zero, skip the rotations
        x_d    = '0;
        y_d    = '0;
        z_d    = '0;
        done_d = 1'b1;
      end else if (dx_i[DXW-1]) begin
        // fold the left half-plane onto the right one
        x_d    = -x0;
        y_d    = -y0;
        z_d    = dy_i[DXW-1] ? -PI_Q30 : PI_Q30;
        busy_d = 1'b1;
      end else begin
        x_d    = x0;
        y_d    = y0;
        z_d    = '0;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (!y_q[XW-1]) begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + ang;
      end else begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - ang;
      end
      iter_d = iter_q + 1'b1;
      if (iter_q == IW'(ITERS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      iter_q <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign res_o.done = done_q;
  assign res_o.x    = x_q;
  assign res_o.z    = z_q;

endmodule

@@ rtl/psc_post.sv @@
// Gain compensation, angle wrap, steering gain and saturation over one shared multiplier.
module psc_post #(
  parameter int FRAC_BITS = psc_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  psc_pkg::cordic_res_t                cordic_i,
  input  logic signed [psc_pkg::HEAD_W-1:0]   heading_i,
  input  logic [psc_pkg::SPEED_W-1:0]         max_speed_i,
  input  logic [psc_pkg::GAIN_W-1:0]          turn_gain_i,
  output psc_pkg::post_res_t                  res_o
);
  import psc_pkg::*;

  localparam int ZS = 30 - FRAC_BITS;
  localparam longint PiFxVal = (longint'(PI_Q30) + (64'sd1 <<< (ZS - 1))) >>> ZS;
  localparam logic signed [DW-1:0] PiFx    = DW'(PiFxVal);
  localparam logic signed [DW-1:0] TwoPiFx = DW'(2 * PiFxVal);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_RATE = 2'd1;
  localparam logic [1:0] PH_SAT  = 2'd2;

  logic [1:0]                phase_q;
  logic                      done_q;
  logic signed [PW-1:0]      prod_q, prod;
  logic signed [MW-1:0]      mul_a, mul_b;
  logic signed [DW-1:0]      diff_q, diff0, diff_w;
  logic [SPEED_W-1:0]        speed_q;
  logic signed [RATE_W-1:0]  rate_q;
  logic signed [XW-1:0]      x_pos;
  logic                      zneg, pneg;
  logic [ZW-1:0]             zmag, zr;
  logic signed [BW-1:0]      bearing;
  logic [PW-1:0]             pmag, pr, dist_fx;

  // clamp a negative CORDIC residue to zero
  assign x_pos = cordic_i.x[XW-1] ? '0 : cordic_i.x;

  // bearing: Q30 down to FRAC_BITS, half away from zero
  assign zneg    = cordic_i.z[ZW-1];
  assign zmag    = zneg ? ZW'(-cordic_i.z) : ZW'(cordic_i.z);
  assign zr      = (zmag + (ZW'(1) << (ZS - 1))) >> ZS;
  assign bearing = zneg ? -BW'(zr) : BW'(zr);

  // single wrap step of the error
  assign diff0 = DW'(bearing) - DW'(heading_i);
  always_comb begin
    if (diff0 > PiFx) begin
      diff_w = diff0 - TwoPiFx;
    end else if (diff0 < -PiFx) begin
      diff_w = diff0 + TwoPiFx;
    end else begin
      diff_w = diff0;
    end
  end

  // shared multiplier: distance scaling first, then the steering gain
  assign mul_a = (phase_q == PH_IDLE) ? MW'(x_pos) : MW'($signed({1'b0, turn_gain_i}));
  assign mul_b = (phase_q == PH_IDLE) ? KCOMP_Q30 : MW'(diff_q);
  assign prod  = mul_a * mul_b;

  assign dist_fx = (PW'(prod_q) + (PW'(1) << (DIST_SHIFT - 1))) >> DIST_SHIFT;
  assign pneg = prod_q[PW-1];
  assign pmag = pneg ? PW'(-prod_q) : PW'(prod_q);
  assign pr   = (pmag + (PW'(1) << (RATE_SHIFT - 1))) >> RATE_SHIFT;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (phase_q)
        PH_IDLE: if (start_i) phase_q <= PH_RATE;
        PH_RATE: phase_q <= PH_SAT;
        PH_SAT: begin
          phase_q <= PH_IDLE;
          done_q  <= 1'b1;
        end
        default: phase_q <= PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (phase_q)
      PH_IDLE: begin
        prod_q <= prod;
        diff_q <= diff_w;
      end
      PH_RATE: begin
        speed_q <= (dist_fx < PW'(max_speed_i)) ? SPEED_W'(dist_fx) : max_speed_i;
        prod_q  <= prod;
      end
      PH_SAT: begin
        if (!pneg && pr > PW'((1 << (RATE_W - 1)) - 1)) begin
          rate_q <= {1'b0, {(RATE_W - 1){1'b1}}};
        end else if (pneg && pr > PW'(1 << (RATE_W - 1))) begin
          rate_q <= {1'b1, {(RATE_W - 1){1'b0}}};
        end else begin
          rate_q <= pneg ? -RATE_W'(pr) : RATE_W'(pr);
        end
      end
      default: prod_q <= prod_q;
    endcase
  end

  assign res_o.done  = done_q;
  assign res_o.speed = speed_q;
  assign res_o.rate  = rate_q;

endmodule

@@ rtl/pursuit_steering_controller_top.sv @@
// Top level of the pursuit steering controller: pose store, sequencer and output register.
//
//  channel  | direction | word contents (lowest bit first)
//  ---------+-----------+-------------------------------------------------------
//  s_axis   | in        | tuser: kind; tdata: pos_x, pos_y, heading, zero pad
//  m_axis   | out       | tdata: linear_speed, angular_rate, zero pad
//  cfg      | in        | cfg_idx_i selects max_speed (0) or turn_gain (1)
//
// A tick with both poses seen runs from acceptance until s_axis_tready is high again
// through the CORDIC unit at one rotation per cycle, then the shared multiplier of the
// post stage and the output load, which waits while the output register is full.
// A tick on a zero vector skips the rotations. s_axis_tready is low while a tick is in work.
// A finished result holds in the output register until taken; a further result waits
// in its last stage until the register is free. Reset clears both poses and seen flags.
module pursuit_steering_controller_top #(
  parameter int FRAC_BITS         = psc_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_ITERATIONS = psc_pkg::CORDIC_ITER_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [psc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // pos_x, pos_y, heading
  input  logic [1:0]                          s_axis_tuser,   // kind
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [psc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,   // linear_speed, angular_rate
  input  logic                                cfg_we_i,
  input  logic                                cfg_idx_i,
  input  logic [psc_pkg::CFG_W-1:0]           cfg_wdata_i
);
  import psc_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CORDIC = 2'd1;
  localparam logic [1:0] ST_POST   = 2'd2;
  localparam logic [1:0] ST_HOLD   = 2'd3;

  logic [1:0]                state_q, state_d;
  logic [SPEED_W-1:0]        max_speed_q;
  logic [GAIN_W-1:0]         turn_gain_q;
  logic signed [POS_W-1:0]   target_x_q, target_y_q, own_x_q, own_y_q;
  logic signed [HEAD_W-1:0]  own_heading_q;
  logic                      target_seen_q, own_seen_q;
  logic                      in_acc, cordic_start, post_start, out_load, m_valid_q;
  logic [SPEED_W-1:0]        speed_q;
  logic signed [RATE_W-1:0]  rate_q;
  logic signed [POS_W-1:0]   in_x, in_y;
  logic signed [HEAD_W-1:0]  in_head;
  logic signed [DXW-1:0]     dx, dy;
  cordic_res_t               cordic_res;
  post_res_t                 post_res;

  // unpack the input word
  assign in_x    = s_axis_tdata[POS_W-1:0];
  assign in_y    = s_axis_tdata[2*POS_W-1:POS_W];
  assign in_head = s_axis_tdata[2*POS_W+HEAD_W-1:2*POS_W];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // a tick before both poses are known yields nothing
  assign cordic_start = in_acc && (s_axis_tuser == KIND_TICK) && target_seen_q && own_seen_q;
  assign post_start   = (state_q == ST_CORDIC) && cordic_res.done;
  assign out_load     = (state_q == ST_HOLD) && (!m_valid_q || m_axis_tready);

  assign dx = DXW'(target_x_q) - DXW'(own_x_q);
  assign dy = DXW'(target_y_q) - DXW'(own_y_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (cordic_start) state_d = ST_CORDIC;
      ST_CORDIC: if (cordic_res.done) state_d = ST_POST;
      ST_POST:   if (post_res.done) state_d = ST_HOLD;
      ST_HOLD:   if (out_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      max_speed_q   <= MAX_SPEED_RST;
      turn_gain_q   <= TURN_GAIN_RST;
      target_x_q    <= '0;
      target_y_q    <= '0;
      own_x_q       <= '0;
      own_y_q       <= '0;
      own_heading_q <= '0;
      target_seen_q <= 1'b0;
      own_seen_q    <= 1'b0;
      m_valid_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MAX_SPEED: max_speed_q <= cfg_wdata_i;
          REG_TURN_GAIN: turn_gain_q <= cfg_wdata_i[GAIN_W-1:0];
          default:       max_speed_q <= max_speed_q;
        endcase
      end
      // store poses; the heading of a target update is dropped
      if (in_acc && s_axis_tuser == KIND_TARGET) begin
        target_x_q    <= in_x;
        target_y_q    <= in_y;
        target_seen_q <= 1'b1;
      end
      if (in_acc && s_axis_tuser == KIND_OWN) begin
        own_x_q       <= in_x;
        own_y_q       <= in_y;
        own_heading_q <= in_head;
        own_seen_q    <= 1'b1;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      speed_q <= post_res.speed;
      rate_q  <= post_res.rate;
    end
  end

  psc_cordic #(
    .ITERS (CORDIC_ITERATIONS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .dx_i    (dx),
    .dy_i    (dy),
    .res_o   (cordic_res)
  );

  psc_post #(
    .FRAC_BITS (FRAC_BITS)
  ) u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (post_start),
    .cordic_i    (cordic_res),
    .heading_i   (own_heading_q),
    .max_speed_i (max_speed_q),
    .turn_gain_i (turn_gain_q),
    .res_o       (post_res)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - SPEED_W - RATE_W){1'b0}}, rate_q, speed_q};

  // a new result appears only from the final stage
  a_valid_from_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_HOLD))
    else $error("result word raised outside the output load");

  // the rotations start only once both poses are known
  a_start_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cordic_start |-> (target_seen_q && own_seen_q))
    else $error("tick processed before both poses seen");

  // the post stage finishes only while the sequencer waits for it
  a_post_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    post_res.done |-> (state_q == ST_POST))
    else $error("post stage finished out of sequence");

  // a waiting result is not overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("pending result word changed");

endmodule

@@ tb/tb_pursuit_steering_controller_top.sv @@
// Self-checking bench for the pursuit steering controller: directed and random pose and tick words.
module tb_pursuit_steering_controller_top;
  import psc_pkg::*;

  typedef logic signed [POS_W-1:0]  coord_t;
  typedef logic signed [HEAD_W-1:0] head_t;
  typedef logic [SPEED_W-1:0]       speed_t;
  typedef logic signed [RATE_W-1:0] rate_t;
  typedef logic [GAIN_W-1:0]        gain_t;

  typedef struct {
    speed_t speed;
    rate_t  rate;
  } steer_cmd_t;

  // Kind code that the block must swallow without effect
  localparam logic [1:0] KIND_SPARE = 2'd3;

  localparam int STEPS           = CORDIC_ITER_DEF;
  localparam int FRAC            = FRAC_BITS_DEF;
  localparam int HEAD_PI         = 12868;
  localparam int SETTLE_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int ITEMS_PER_PHASE = 370;

  localparam longint          HALF_TURN_Q30 = 64'sd3373259426;
  localparam longint unsigned GAIN_COMP_Q30 = 64'd652032874;
  localparam longint          PI_FX = (HALF_TURN_Q30 + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
  localparam longint          RATE_HI = 64'sd262143;
  localparam longint          RATE_LO = -64'sd262144;

  // Tracks both poses and the limits, and holds the commands still owed by the block.
  class steer_ledger;
    longint     goal_x, goal_y, self_x, self_y, self_hdg;
    bit         goal_known, self_known;
    longint     speed_cap = MAX_SPEED_RST;
    longint     gain = TURN_GAIN_RST;
    steer_cmd_t pending_cmds[$];
    int         errors;

    function void set_limits(speed_t spd, gain_t g);
      speed_cap = spd;
      gain      = g;
    endfunction

    static function longint arctan_q30(int i);
      case (i)
        0:  return 843314857;
        1:  return 497837829;
        2:  return 263043837;
        3:  return 133525159;
        4:  return 67021687;
        5:  return 33543516;
        6:  return 16775851;
        7:  return 8388437;
        8:  return 4194283;
        9:  return 2097149;
        10: return 1048576;
        11: return 524288;
        12: return 262144;
        13: return 131072;
        14: return 65536;
        default: return 32768;
      endcase
    endfunction

    static function longint shr_away(longint v, int s);
      longint half;
      half = 64'sd1 <<< (s - 1);
      if (v >= 0) return (v + half) >>> s;
      return -((-v + half) >>> s);
    endfunction

    function steer_cmd_t steer_command();
      steer_cmd_t      c;
      longint          dx, dy, x, y, z, xs, ys, brg, err, r;
      longint unsigned dist_fx;
      int              i;
      dx = goal_x - self_x;
      dy = goal_y - self_y;
      if (dx == 0 && dy == 0) begin
        brg     = 0;
        dist_fx = 0;
      end else begin
        x = dx <<< GUARD_BITS;
        y = dy <<< GUARD_BITS;
        z = 0;
        // fold the left half-plane onto the right before rotating
        if (x < 0) begin
          z = (y >= 0) ? HALF_TURN_Q30 : -HALF_TURN_Q30;
          x = -x;
          y = -y;
        end
        for (i = 0; i < STEPS; i++) begin
          xs = x >>> i;
          ys = y >>> i;
          if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + arctan_q30(i);
          end else begin
            x = x - ys;
            y = y + xs;
            z = z - arctan_q30(i);
          end
        end
        if (x < 0) x = 0;
        dist_fx = ($unsigned(x) * GAIN_COMP_Q30 + (64'd1 << (29 + GUARD_BITS)))
                  >> (30 + GUARD_BITS);
        brg     = shr_away(z, 30 - FRAC);
      end
      // one wrap step only, so a heading past pi may leave the error just outside
      err = brg - self_hdg;
      if (err > PI_FX) err = err - 2 * PI_FX;
      else if (err < -PI_FX) err = err + 2 * PI_FX;
      r = shr_away(gain * err, RATE_SHIFT);
      if (r > RATE_HI) r = RATE_HI;
      if (r < RATE_LO) r = RATE_LO;
      c.speed = (dist_fx < $unsigned(speed_cap)) ? speed_t'(dist_fx) : speed_t'(speed_cap);
      c.rate  = rate_t'(r);
      return c;
    endfunction

    // Note one accepted input word.
    function void take_word(logic [1:0] kind, coord_t px, coord_t py, head_t hdg);
      case (kind)
        KIND_TARGET: begin
          goal_x     = px;
          goal_y     = py;
          goal_known = 1'b1;
        end
        KIND_OWN: begin
          self_x     = px;
          self_y     = py;
          self_hdg   = hdg;
          self_known = 1'b1;
        end
        KIND_TICK: begin
          if (goal_known && self_known) pending_cmds.push_back(steer_command());
        end
        default: ;
      endcase
    endfunction

    // Check one accepted command word against the oldest one owed.
    function void match_command(logic [OUT_TDATA_W-1:0] word);
      steer_cmd_t want;
      speed_t     got_speed;
      rate_t      got_rate;
      got_speed = word[SPEED_W-1:0];
      got_rate  = word[SPEED_W +: RATE_W];
      if (pending_cmds.size() == 0) begin
        $error("unexpected command word: linear_speed %0d, angular_rate %0d",
               got_speed, got_rate);
        errors++;
        return;
      end
      want = pending_cmds.pop_front();
      if (got_speed !== want.speed) begin
        $error("linear_speed: expected %0d, got %0d", want.speed, got_speed);
        errors++;
      end
      if (got_rate !== want.rate) begin
        $error("angular_rate: expected %0d, got %0d", want.rate, got_rate);
        errors++;
      end
    endfunction

    function int pending();
      return pending_cmds.size();
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // pos_x, pos_y, heading, zero pad
  logic [1:0]             s_axis_tuser = '0;   // kind
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // linear_speed, angular_rate, zero pad
  logic                   cfg_we_i = 1'b0;
  logic                   cfg_idx_i = 1'b0;
  logic [CFG_W-1:0]       cfg_wdata_i = '0;

  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          quiet_cycles = 0;
  coord_t      anchor_x = '0;
  coord_t      anchor_y = '0;
  steer_ledger ledger = new;

  pursuit_steering_controller_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Take command words, and stall the output at random per the current phase.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) ledger.match_command(m_axis_tdata);
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Give up once neither side has moved a word for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one input word, idling first at random, and note it once taken.
  // Leave tvalid high afterwards so that back-to-back words go out without a gap.
  task automatic send_word(input logic [1:0] kind, input coord_t px, input coord_t py,
                           input head_t hdg);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= IN_TDATA_W'({$urandom, $urandom});
      s_axis_tuser  <= 2'($urandom);
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {{(IN_TDATA_W - 2 * POS_W - HEAD_W){1'b0}}, hdg, py, px};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    ledger.take_word(kind, px, py, hdg);
    if (kind == KIND_TARGET || kind == KIND_OWN) begin
      anchor_x = px;
      anchor_y = py;
    end
  endtask

  // Hold the input until every owed command is back, then let the pipe drain.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write both registers on back-to-back edges; call only while the block is idle.
  task automatic program_limits(input speed_t spd, input gain_t g);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_MAX_SPEED;
    cfg_wdata_i <= spd;
    @(posedge clk_i);
    cfg_idx_i   <= REG_TURN_GAIN;
    cfg_wdata_i <= {{(CFG_W - GAIN_W){1'b0}}, g};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    ledger.set_limits(spd, g);
  endtask

  // Mostly well-formed pose and tick traffic. Positions often sit on or next to the last
  // pose sent, so zero, tiny and axis-aligned vectors turn up regularly.
  task automatic random_words(input int count);
    logic [1:0] kind;
    coord_t     px, py;
    head_t      hdg;
    int         pick, n;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      kind = (pick < 30) ? KIND_TARGET : (pick < 60) ? KIND_OWN :
             (pick < 96) ? KIND_TICK : KIND_SPARE;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        px = coord_t'($urandom);
        py = coord_t'($urandom);
      end else if (pick < 70) begin
        px = anchor_x + coord_t'($urandom_range(0, 64) - 32);
        py = anchor_y + coord_t'($urandom_range(0, 64) - 32);
      end else if (pick < 85) begin
        px = anchor_x;
        py = anchor_y;
      end else if ($urandom_range(0, 1) != 0) begin
        px = anchor_x;
        py = coord_t'($urandom);
      end else begin
        px = coord_t'($urandom);
        py = anchor_y;
      end
      // headings mostly within plus or minus pi, now and then the full field
      if ($urandom_range(0, 4) != 0) hdg = head_t'(int'($urandom_range(0, 2 * HEAD_PI)) - HEAD_PI);
      else hdg = head_t'($urandom);
      send_word(kind, px, py, hdg);
      if ($urandom_range(0, 149) == 0) settle();
    end
    settle();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words at the reset limits, no idling on either side.
    send_word(KIND_TICK, 5, 7, 100);                     // nothing seen yet: no command
    send_word(KIND_TARGET, 262143, 262143, -16384);      // heading of a target is dropped
    send_word(KIND_TICK, 0, 0, 0);                       // own pose still unseen
    send_word(KIND_OWN, -262144, -262144, HEAD_PI);      // longest vector, speed clamps
    send_word(KIND_TICK, -1, -1, -1);                    // tick fields all ones, ignored
    send_word(KIND_SPARE, 19'h2AAAA, 19'h55555, 15'h2AAA);
    send_word(KIND_TICK, 0, 0, 0);                       // spare kind left no trace
    send_word(KIND_OWN, 262143, 262143, -HEAD_PI);       // zero vector
    send_word(KIND_TICK, 0, 0, 0);
    send_word(KIND_TARGET, -4096, 0, 0);                 // bearing exactly pi
    send_word(KIND_OWN, 0, 0, -16384);                   // heading below minus pi
    send_word(KIND_TICK, 0, 0, 0);
    send_word(KIND_TARGET, -4096, -1, 0);                // bearing just short of minus pi
    send_word(KIND_TICK, 0, 0, 0);
    send_word(KIND_OWN, 0, 0, 16383);                    // heading above pi
    send_word(KIND_TICK, 0, 0, 0);
    send_word(KIND_TARGET, -262144, 262143, 0);
    send_word(KIND_OWN, 262143, -262144, 0);
    send_word(KIND_TICK, 0, 0, 0);
    send_word(KIND_TARGET, 0, 5, 0);
    send_word(KIND_OWN, 0, 0, 0);
    send_word(KIND_TICK, 0, 0, 0);
    send_word(KIND_TARGET, 1, 0, 0);                     // one step along x
    send_word(KIND_TICK, 0, 0, 0);
    settle();

    // Random phases, each under its own limits and idling pattern.
    program_limits(16'hFFFF, 12'hFFF);
    random_words(ITEMS_PER_PHASE);

    program_limits(16'h0000, 12'h000);
    send_idle_pct = 64;
    random_words(ITEMS_PER_PHASE);

    program_limits(speed_t'($urandom), gain_t'($urandom));
    send_idle_pct  = 0;
    recv_stall_pct = 64;
    random_words(ITEMS_PER_PHASE);

    program_limits(speed_t'($urandom_range(0, 16384)), gain_t'($urandom));
    send_idle_pct  = 26;
    recv_stall_pct = 26;
    random_words(ITEMS_PER_PHASE);

    program_limits(16'd1, 12'd1);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    random_words(ITEMS_PER_PHASE);

    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ pursuit_steering_controller_top.f @@
rtl/psc_pkg.sv
rtl/psc_cordic.sv
rtl/psc_post.sv
rtl/pursuit_steering_controller_top.sv
tb/tb_pursuit_steering_controller_top.sv
